### rtl/slx_pkg.sv
// Shared types, codes and helper functions of the command line lexer.
`default_nettype none
package slx_pkg;

	localparam int MAX_RES = 3;
	localparam int CNT_W   = 2;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	// Lexer modes
	localparam logic [2:0] M_IDLE   = 3'd0;
	localparam logic [2:0] M_WORD   = 3'd1;
	localparam logic [2:0] M_SQ     = 3'd2;
	localparam logic [2:0] M_DQ     = 3'd3;
	localparam logic [2:0] M_AFTERQ = 3'd4;
	localparam logic [2:0] M_GT     = 3'd5;
	localparam logic [2:0] M_LT     = 3'd6;

	// Token kinds
	localparam logic [2:0] K_WORD    = 3'd0;
	localparam logic [2:0] K_PIPE    = 3'd1;
	localparam logic [2:0] K_OUT     = 3'd2;
	localparam logic [2:0] K_APPEND  = 3'd3;
	localparam logic [2:0] K_IN      = 3'd4;
	localparam logic [2:0] K_HEREDOC = 3'd5;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic       token_done;
		logic [2:0] token_kind;
		logic       line_done;
		logic       run_last;
	} res_t;

	// All results caused by one input byte
	typedef struct packed {
		logic [CNT_W-1:0]     cnt;
		res_t [MAX_RES-1:0]   slot;
	} bundle_t;

	function automatic res_t mk_byte(input logic [7:0] b);
		res_t r;
		r          = '0;
		r.has_byte = 1'b1;
		r.out_byte = b;
		return r;
	endfunction

	function automatic res_t mk_end(input logic [2:0] kind);
		res_t r;
		r            = '0;
		r.token_done = 1'b1;
		r.token_kind = kind;
		return r;
	endfunction

	function automatic bundle_t add_res(input bundle_t bin, input res_t r);
		bundle_t bo;
		bo = bin;
		if (bin.cnt < CNT_W'(MAX_RES)) begin
			bo.slot[bin.cnt] = r;
			bo.cnt           = bin.cnt + 1'b1;
		end
		return bo;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage
`default_nettype wire

### rtl/slx_front.sv
// Front end: classify each byte, track the lexer mode, build its result bundle.
`default_nettype none
module slx_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_ok,
	input  wire logic [7:0]       char_byte,
	input  wire logic             end_of_line,
	output slx_pkg::bundle_t      bundle,
	output logic                  bundle_push
);

	logic [2:0]        mode_q;
	logic [2:0]        mode_d;
	logic [2:0]        fi_mode;
	logic              fi_has;
	slx_pkg::res_t     fi_res;
	logic              is_op;
	slx_pkg::bundle_t  b;

	// Byte handling from between tokens depends on the byte alone
	always_comb begin
		fi_has  = 1'b0;
		fi_res  = '0;
		fi_mode = slx_pkg::M_IDLE;
		if (slx_pkg::is_space(char_byte)) begin
			fi_mode = slx_pkg::M_IDLE;
		end else if (char_byte == slx_pkg::CH_SQUOTE) begin
			fi_mode = slx_pkg::M_SQ;
		end else if (char_byte == slx_pkg::CH_DQUOTE) begin
			fi_mode = slx_pkg::M_DQ;
		end else if (char_byte == slx_pkg::CH_PIPE) begin
			fi_has = 1'b1;
			fi_res = slx_pkg::mk_end(slx_pkg::K_PIPE);
		end else if (char_byte == slx_pkg::CH_GT) begin
			fi_mode = slx_pkg::M_GT;
		end else if (char_byte == slx_pkg::CH_LT) begin
			fi_mode = slx_pkg::M_LT;
		end else begin
			fi_has  = 1'b1;
			fi_res  = slx_pkg::mk_byte(char_byte);
			fi_mode = slx_pkg::M_WORD;
		end
	end

	assign is_op = slx_pkg::is_space(char_byte) || (char_byte == slx_pkg::CH_GT) ||
		(char_byte == slx_pkg::CH_LT) || (char_byte == slx_pkg::CH_PIPE);

	always_comb begin
		b      = '0;
		mode_d = mode_q;
		case (mode_q)
			slx_pkg::M_WORD: begin
				if (is_op) begin
					b      = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_WORD));
					mode_d = fi_mode;
					if (fi_has) b = slx_pkg::add_res(b, fi_res);
				end else begin
					b = slx_pkg::add_res(b, slx_pkg::mk_byte(char_byte));
				end
			end
			slx_pkg::M_SQ: begin
				if (char_byte == slx_pkg::CH_SQUOTE) mode_d = slx_pkg::M_AFTERQ;
				else b = slx_pkg::add_res(b, slx_pkg::mk_byte(char_byte));
			end
			slx_pkg::M_DQ: begin
				if (char_byte == slx_pkg::CH_DQUOTE) mode_d = slx_pkg::M_AFTERQ;
				else b = slx_pkg::add_res(b, slx_pkg::mk_byte(char_byte));
			end
			slx_pkg::M_AFTERQ: begin
				if (char_byte == slx_pkg::CH_SQUOTE) begin
					mode_d = slx_pkg::M_SQ;
				end else if (char_byte == slx_pkg::CH_DQUOTE) begin
					mode_d = slx_pkg::M_DQ;
				end else begin
					b      = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_WORD));
					mode_d = fi_mode;
					if (fi_has) b = slx_pkg::add_res(b, fi_res);
				end
			end
			slx_pkg::M_GT: begin
				if (char_byte == slx_pkg::CH_GT) begin
					b      = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_APPEND));
					mode_d = slx_pkg::M_IDLE;
				end else begin
					b      = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_OUT));
					mode_d = fi_mode;
					if (fi_has) b = slx_pkg::add_res(b, fi_res);
				end
			end
			slx_pkg::M_LT: begin
				if (char_byte == slx_pkg::CH_LT) begin
					b      = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_HEREDOC));
					mode_d = slx_pkg::M_IDLE;
				end else begin
					b      = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_IN));
					mode_d = fi_mode;
					if (fi_has) b = slx_pkg::add_res(b, fi_res);
				end
			end
			default: begin
				mode_d = fi_mode;
				if (fi_has) b = slx_pkg::add_res(b, fi_res);
			end
		endcase

		// Close whatever is open at end of line
		if (end_of_line) begin
			case (mode_d)
				slx_pkg::M_WORD, slx_pkg::M_SQ, slx_pkg::M_DQ, slx_pkg::M_AFTERQ:
					b = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_WORD));
				slx_pkg::M_GT: b = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_OUT));
				slx_pkg::M_LT: b = slx_pkg::add_res(b, slx_pkg::mk_end(slx_pkg::K_IN));
				default: ;
			endcase
			mode_d = slx_pkg::M_IDLE;
			if (b.cnt == '0) b.cnt = slx_pkg::CNT_W'(1);
		end

		// Flag the last result of this byte
		for (int i = 0; i < slx_pkg::MAX_RES; i++) begin
			if (b.cnt == slx_pkg::CNT_W'(i + 1)) begin
				b.slot[i].run_last  = 1'b1;
				b.slot[i].line_done = end_of_line;
			end
		end
	end

	assign bundle      = b;
	assign bundle_push = in_ok && (b.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= slx_pkg::M_IDLE;
		end else if (in_ok) begin
			mode_q <= mode_d;
		end
	end

endmodule
`default_nettype wire

### rtl/slx_queue.sv
// Short bundle queue between the front and back ends.
`default_nettype none
module slx_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire slx_pkg::bundle_t wdata,
	input  wire logic             rd,
	output slx_pkg::bundle_t      rdata,
	output logic                  q_full,
	output logic                  q_empty
);

	slx_pkg::bundle_t                 mem_q [slx_pkg::QDEPTH];
	logic [slx_pkg::QPTR_W-1:0]       wptr_q;
	logic [slx_pkg::QPTR_W-1:0]       rptr_q;
	logic [slx_pkg::QCNT_W-1:0]       cnt_q;
	logic                             do_wr;
	logic                             do_rd;

	assign q_full  = (cnt_q == slx_pkg::QCNT_W'(slx_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/slx_back.sv
// Back end: unpack bundles into single results held in an output register.
`default_nettype none
module slx_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slx_pkg::bundle_t head,
	input  wire logic             head_valid,
	output logic                  head_pop,
	input  wire logic             out_take,
	output logic                  out_valid,
	output slx_pkg::res_t         out_res
);

	logic                       out_valid_q;
	slx_pkg::res_t              out_res_q;
	logic [slx_pkg::CNT_W-1:0]  idx_q;
	logic                       load;
	logic                       last_slot;

	assign load      = head_valid && (!out_valid_q || out_take);
	assign last_slot = (idx_q == (head.cnt - 1'b1));
	assign head_pop  = load && last_slot;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk) begin
		if (load) out_res_q <= head.slot[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_slot ? '0 : idx_q + 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/shell_command_lexer.sv
// Top level of the streaming command line lexer.
//
// Channel   Handshake             Payload
// input     push / full           char_byte, end_of_line
// result    pop / empty           has_byte, out_byte, token_done, token_kind,
//                                 line_done, run_last
//
// One byte is accepted per cycle while the bundle queue has room; a byte
// yields zero to three results, and the back end emits one result per cycle
// while results are popped. The first result of a byte reaches the result
// ports through the queue write and then the output register load. Sustained
// input rate is one byte per cycle while bytes make at most one result and
// results are popped; bytes that make two or three results hold the output
// port for each result in turn. Reset clears the lexer mode to between tokens
// and empties the queue and output register. Either side may stall freely.
`default_nettype none
module shell_command_lexer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_byte,
	input  wire logic       end_of_line,
	input  wire logic       pop,
	output logic            empty,
	output logic            has_byte,
	output logic [7:0]      out_byte,
	output logic            token_done,
	output logic [2:0]      token_kind,
	output logic            line_done,
	output logic            run_last
);

	slx_pkg::bundle_t  front_bundle;
	slx_pkg::bundle_t  head_bundle;
	slx_pkg::res_t     res;
	logic              bundle_push;
	logic              q_full;
	logic              q_empty;
	logic              head_pop;
	logic              out_valid;
	logic              in_ok;
	logic              out_take;

	// Accept a transaction whenever the queue has room
	assign full     = q_full;
	assign in_ok    = push && !q_full;
	assign empty    = !out_valid;
	assign out_take = pop && out_valid;

	slx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ok       (in_ok),
		.char_byte   (char_byte),
		.end_of_line (end_of_line),
		.bundle      (front_bundle),
		.bundle_push (bundle_push)
	);

	slx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (bundle_push),
		.wdata   (front_bundle),
		.rd      (head_pop),
		.rdata   (head_bundle),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	slx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_bundle),
		.head_valid (!q_empty),
		.head_pop   (head_pop),
		.out_take   (out_take),
		.out_valid  (out_valid),
		.out_res    (res)
	);

	assign has_byte   = res.has_byte;
	assign out_byte   = res.out_byte;
	assign token_done = res.token_done;
	assign token_kind = res.token_kind;
	assign line_done  = res.line_done;
	assign run_last   = res.run_last;

endmodule
`default_nettype wire
